[rtl/core/teq_pkg.sv]
package teq_pkg;

  // Number of cells in the queue and the fixed field widths.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [ID_W-1:0]          ID_MAX   = '1;
  localparam logic [ID_W-1:0]          ID_FIRST = ID_W'(1);
  localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_POST   = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STS_POSTED    = 3'd0,
    STS_FULL      = 3'd1,
    STS_CANCELLED = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FIRED     = 3'd4,
    STS_NONE_DUE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_e;

  // Contents of one cell of the queue.
  typedef struct packed {
    logic                     valid;
    logic signed [TIME_W-1:0] due_time;
    logic [ID_W-1:0]          id;
    logic [TAG_W-1:0]         tag;
  } entry_t;

  // Request fields broadcast to every cell.
  typedef struct packed {
    logic signed [TIME_W-1:0] due_time;
    logic [TAG_W-1:0]         tag;
    logic [ID_W-1:0]          new_id;
    logic [ID_W-1:0]          cancel_id;
  } bcast_t;

  // Per-cycle command from the sequencer to the cells.
  typedef struct packed {
    logic eval;
    logic insert;
    logic remove;
  } cell_cmd_t;

  // Prefix OR from the head: bit i is set when any bit at or below i is set.
  function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] r;
    r = v;
    for (int unsigned s = 1; s < DEPTH; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

endpackage

[rtl/core/teq_req_if.sv]
interface teq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           func;
  logic signed [teq_pkg::TIME_W-1:0]    due_time_us;
  logic [teq_pkg::TAG_W-1:0]            event_tag;
  logic [teq_pkg::ID_W-1:0]             cancel_id;
  logic signed [teq_pkg::TIME_W-1:0]    now_us;

  modport source (output valid, func, due_time_us, event_tag, cancel_id, now_us,
                  input ready);
  modport sink (input valid, func, due_time_us, event_tag, cancel_id, now_us,
                output ready);
endinterface

[rtl/core/teq_rsp_if.sv]
interface teq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           status;
  logic [teq_pkg::ID_W-1:0]             evt_id;
  logic [teq_pkg::TAG_W-1:0]            fired_tag;
  logic signed [teq_pkg::TIME_W-1:0]    fire_time_us;
  logic [teq_pkg::CNT_W-1:0]            occupancy;

  modport source (output valid, status, evt_id, fired_tag, fire_time_us, occupancy,
                  input ready);
  modport sink (input valid, status, evt_id, fired_tag, fire_time_us, occupancy,
                output ready);
endinterface

[rtl/core/teq_cell.sv]
module teq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  teq_pkg::cell_cmd_t cmd_i,
  input  teq_pkg::bcast_t    bcast_i,
  input  teq_pkg::entry_t    left_i,
  input  logic               left_gt_i,
  input  teq_pkg::entry_t    right_i,
  input  logic               rm_i,
  output teq_pkg::entry_t    entry_o,
  output logic               gt_o,
  output logic               match_o
);

  logic                             valid_q, valid_d;
  logic signed [teq_pkg::TIME_W-1:0] time_q, time_d;
  logic [teq_pkg::ID_W-1:0]          id_q, id_d;
  logic [teq_pkg::TAG_W-1:0]         tag_q, tag_d;
  logic                             gt_q, gt_d;
  logic                             match_q, match_d;

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    id_d    = id_q;
    tag_d   = tag_q;
    gt_d    = gt_q;
    match_d = match_q;

    // The new time belongs ahead of this cell if the cell is empty or later.
    if (cmd_i.eval) begin
      gt_d    = !valid_q || (bcast_i.due_time < time_q);
      match_d = valid_q && (bcast_i.cancel_id != '0) && (id_q == bcast_i.cancel_id);
    end

    if (cmd_i.insert && gt_q) begin
      if (left_gt_i) begin
        valid_d = left_i.valid;
        time_d  = left_i.due_time;
        id_d    = left_i.id;
        tag_d   = left_i.tag;
      end else begin
        valid_d = 1'b1;
        time_d  = bcast_i.due_time;
        id_d    = bcast_i.new_id;
        tag_d   = bcast_i.tag;
      end
    end else if (cmd_i.remove && rm_i) begin
      valid_d = right_i.valid;
      time_d  = right_i.due_time;
      id_d    = right_i.id;
      tag_d   = right_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      gt_q    <= gt_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
    tag_q  <= tag_d;
  end

  assign entry_o.valid    = valid_q;
  assign entry_o.due_time = time_q;
  assign entry_o.id       = id_q;
  assign entry_o.tag      = tag_q;
  assign gt_o             = gt_q;
  assign match_o          = match_q;

endmodule

[rtl/core/timed_event_queue_unit.sv]
// Channel  Direction  Contents
// req_i    sink       func, due_time_us, event_tag, cancel_id, now_us
// rsp_o    source     status, evt_id, fired_tag, fire_time_us, occupancy
//
// Every request passes through a compare state, in which all cells compare
// their entry with the broadcast request, and an apply state, in which the row
// shifts and the response is registered. A new request is taken only as the
// current one commits in the apply state. Reset empties the row at once; the
// stored times, ids and tags are left as they were. A stalled response holds
// the block in its apply state until the response slot frees.
module timed_event_queue_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  teq_req_if.sink    req_i,
  teq_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = teq_pkg::DEPTH;

  teq_pkg::state_e state_q, state_d;

  // Request captured at acceptance, held through the compare and apply states.
  logic [1:0]                        func_q;
  logic signed [teq_pkg::TIME_W-1:0] due_q;
  logic [teq_pkg::TAG_W-1:0]         tag_q;
  logic [teq_pkg::ID_W-1:0]          cid_q;
  logic signed [teq_pkg::TIME_W-1:0] now_q;

  logic [teq_pkg::ID_W-1:0]  next_id_q, next_id_d;
  logic [teq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      head_due_q, head_due_d;

  // Registered response slot.
  logic                              out_vld_q, out_vld_d;
  logic [2:0]                        sts_q, sts_d;
  logic [teq_pkg::ID_W-1:0]          eid_q, eid_d;
  logic [teq_pkg::TAG_W-1:0]         ftag_q, ftag_d;
  logic signed [teq_pkg::TIME_W-1:0] ftime_q, ftime_d;
  logic [teq_pkg::CNT_W-1:0]         occ_q;

  logic in_rdy, accept, commit;
  logic post_ok, rem_en;

  teq_pkg::entry_t    entries   [DEPTH];
  teq_pkg::entry_t    left_ent  [DEPTH];
  teq_pkg::entry_t    right_ent [DEPTH];
  logic [DEPTH-1:0]   gt_vec, match_vec, vld_vec, left_gt, hit_vec, rm_mask;
  teq_pkg::cell_cmd_t cmd;
  teq_pkg::bcast_t    bcast;

  // Neighbour wiring: each cell sees the cell nearer the head on its left and
  // the one further back on its right. The ends see an empty entry.
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      vld_vec[i] = entries[i].valid;
      if (i == 0) begin
        left_ent[i] = '0;
        left_gt[i]  = 1'b0;
      end else begin
        left_ent[i] = entries[i-1];
        left_gt[i]  = gt_vec[i-1];
      end
      if (i == DEPTH - 1) begin
        right_ent[i] = '0;
      end else begin
        right_ent[i] = entries[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    teq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .bcast_i   (bcast),
      .left_i    (left_ent[g]),
      .left_gt_i (left_gt[g]),
      .right_i   (right_ent[g]),
      .rm_i      (rm_mask[g]),
      .entry_o   (entries[g]),
      .gt_o      (gt_vec[g]),
      .match_o   (match_vec[g])
    );
  end

  assign bcast.due_time  = due_q;
  assign bcast.tag       = tag_q;
  assign bcast.new_id    = next_id_q;
  assign bcast.cancel_id = cid_q;

  // The head is due when its time is negative, the maximum, or not after now.
  assign head_due_d = entries[0].valid &&
                      (entries[0].due_time[teq_pkg::TIME_W-1] ||
                       (entries[0].due_time == teq_pkg::TIME_MAX) ||
                       !(now_q < entries[0].due_time));

  // Cells from the first hit to the tail move one place towards the head. A
  // tick that finds the head due removes it, which shifts the whole row.
  always_comb begin
    hit_vec = '0;
    if (func_q == teq_pkg::FUNC_CANCEL) begin
      hit_vec = match_vec;
    end else if ((func_q == teq_pkg::FUNC_TICK) && head_due_q) begin
      hit_vec = DEPTH'(1);
    end
  end
  assign rm_mask = teq_pkg::prefix_or(hit_vec);

  assign post_ok = (func_q == teq_pkg::FUNC_POST) && !vld_vec[DEPTH-1];
  assign rem_en  = rm_mask[DEPTH-1];

  assign commit = (state_q == teq_pkg::S_APPLY) && (!out_vld_q || rsp_o.ready);
  assign in_rdy = (state_q == teq_pkg::S_IDLE) || commit;
  assign accept = req_i.valid && in_rdy;

  assign cmd.eval   = (state_q == teq_pkg::S_EVAL);
  assign cmd.insert = commit && post_ok;
  assign cmd.remove = commit && rem_en;

  // Sequencer and response formation.
  always_comb begin
    state_d   = state_q;
    next_id_d = next_id_q;
    cnt_d     = cnt_q;
    sts_d     = sts_q;
    eid_d     = eid_q;
    ftag_d    = ftag_q;
    ftime_d   = ftime_q;
    out_vld_d = out_vld_q && !rsp_o.ready;

    case (state_q)
      teq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = teq_pkg::S_EVAL;
        end
      end
      teq_pkg::S_EVAL: begin
        state_d = teq_pkg::S_APPLY;
      end
      teq_pkg::S_APPLY: begin
        if (commit) begin
          state_d   = accept ? teq_pkg::S_EVAL : teq_pkg::S_IDLE;
          out_vld_d = 1'b1;
          sts_d     = teq_pkg::STS_NONE_DUE;
          eid_d     = '0;
          ftag_d    = '0;
          ftime_d   = '0;
          case (func_q)
            teq_pkg::FUNC_POST: begin
              if (post_ok) begin
                sts_d     = teq_pkg::STS_POSTED;
                eid_d     = next_id_q;
                cnt_d     = cnt_q + 1'b1;
                next_id_d = (next_id_q == teq_pkg::ID_MAX) ? teq_pkg::ID_FIRST
                                                           : next_id_q + 1'b1;
              end else begin
                sts_d = teq_pkg::STS_FULL;
              end
            end
            teq_pkg::FUNC_CANCEL: begin
              if (rem_en) begin
                sts_d = teq_pkg::STS_CANCELLED;
                cnt_d = cnt_q - 1'b1;
              end else begin
                sts_d = teq_pkg::STS_NOT_FOUND;
              end
            end
            teq_pkg::FUNC_TICK: begin
              if (head_due_q) begin
                sts_d   = teq_pkg::STS_FIRED;
                eid_d   = entries[0].id;
                ftag_d  = entries[0].tag;
                ftime_d = now_q;
                cnt_d   = cnt_q - 1'b1;
              end
            end
            default: begin
              sts_d = teq_pkg::STS_NONE_DUE;
            end
          endcase
        end
      end
      default: begin
        state_d = teq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= teq_pkg::S_IDLE;
      next_id_q  <= teq_pkg::ID_FIRST;
      cnt_q      <= '0;
      head_due_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      if (cmd.eval) begin
        head_due_q <= head_due_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      due_q  <= req_i.due_time_us;
      tag_q  <= req_i.event_tag;
      cid_q  <= req_i.cancel_id;
      now_q  <= req_i.now_us;
    end
    if (commit) begin
      sts_q   <= sts_d;
      eid_q   <= eid_d;
      ftag_q  <= ftag_d;
      ftime_q <= ftime_d;
      occ_q   <= cnt_d;
    end
  end

  assign req_i.ready        = in_rdy;
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = sts_q;
  assign rsp_o.evt_id       = eid_q;
  assign rsp_o.fired_tag    = ftag_q;
  assign rsp_o.fire_time_us = ftime_q;
  assign rsp_o.occupancy    = occ_q;

  // The occupied cells always form an unbroken run from the head.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("occupied cells do not form a run from the head");

  // The fill count agrees with the cells that hold an entry.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == cnt_q)
    else $error("fill count disagrees with occupied cells");

  // An accepted request always enters the compare cycle next.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == teq_pkg::S_EVAL))
    else $error("accepted request did not enter the compare cycle");

  // Insertion and removal never happen in the same cycle.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.insert && cmd.remove))
    else $error("insert and remove issued together");

endmodule

[tb/tb.sv]
module tb;

  // The request channel can carry a function code that the block does not
  // define; such a request changes nothing and is answered as "nothing due".
  localparam logic [1:0] FUNC_NOP = 2'd3;

  localparam int unsigned N_RANDOM  = 675;
  localparam int unsigned CALM_TAIL = 100;
  localparam int unsigned CYC_LIMIT = 200000;
  localparam int unsigned DRAIN_CYC = 20;

  localparam logic signed [teq_pkg::TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;

  // One request as the sender presents it.
  typedef struct {
    logic [1:0]                        func;
    logic signed [teq_pkg::TIME_W-1:0] due_time;
    logic [teq_pkg::TAG_W-1:0]         tag;
    logic [teq_pkg::ID_W-1:0]          cancel_id;
    logic signed [teq_pkg::TIME_W-1:0] now;
  } request_t;

  // One response as the block should return it.
  typedef struct {
    teq_pkg::status_e                  status;
    logic [teq_pkg::ID_W-1:0]          evt_id;
    logic [teq_pkg::TAG_W-1:0]         fired_tag;
    logic signed [teq_pkg::TIME_W-1:0] fire_time;
    logic [teq_pkg::CNT_W-1:0]         occupancy;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  teq_req_if req_if ();
  teq_rsp_if rsp_if ();

  timed_event_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be driven, and the responses that the accepted
  // requests should produce, oldest first.
  request_t  pending_reqs[$];
  response_t due_responses[$];

  // Our own copy of the event list, kept in due-time order with the head in
  // slot zero, together with the id that the next successful post receives.
  logic signed [teq_pkg::TIME_W-1:0] ev_time [teq_pkg::DEPTH];
  logic [teq_pkg::ID_W-1:0]          ev_id   [teq_pkg::DEPTH];
  logic [teq_pkg::TAG_W-1:0]         ev_tag  [teq_pkg::DEPTH];
  int unsigned                       ev_count = 0;
  logic [teq_pkg::ID_W-1:0]          id_next  = teq_pkg::ID_FIRST;

  // Simulated wall clock that steers the random posts and ticks.
  logic signed [teq_pkg::TIME_W-1:0] wall_now = '0;

  bit          calm     = 1'b0;
  int unsigned n_errors = 0;
  int unsigned cycles   = 0;

  request_t    drv_req;
  int unsigned send_gap  = 0;
  int unsigned take_stall = 0;

  // Closes the gap left by the entry in slot pos.
  task automatic drop_event(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < ev_count; i++) begin
      ev_time[i] = ev_time[i + 1];
      ev_id[i]   = ev_id[i + 1];
      ev_tag[i]  = ev_tag[i + 1];
    end
    ev_count--;
  endtask

  // Applies one accepted request to the event list and returns the response
  // that the block owes for it.
  task automatic apply_request(input request_t r, output response_t e);
    int unsigned                       pos;
    int unsigned                       i;
    bit                                found;
    logic signed [teq_pkg::TIME_W-1:0] head_time;
    e.status    = teq_pkg::STS_NONE_DUE;
    e.evt_id    = '0;
    e.fired_tag = '0;
    e.fire_time = '0;
    case (r.func)
      teq_pkg::FUNC_POST: begin
        if (ev_count >= teq_pkg::DEPTH) begin
          e.status = teq_pkg::STS_FULL;
        end else begin
          // A new event goes behind every entry due at the same time or
          // earlier, so equal times keep their posting order.
          pos = 0;
          while (pos < ev_count && !(r.due_time < ev_time[pos])) pos++;
          for (i = ev_count; i > pos; i--) begin
            ev_time[i] = ev_time[i - 1];
            ev_id[i]   = ev_id[i - 1];
            ev_tag[i]  = ev_tag[i - 1];
          end
          ev_time[pos] = r.due_time;
          ev_id[pos]   = id_next;
          ev_tag[pos]  = r.tag;
          ev_count++;
          e.status = teq_pkg::STS_POSTED;
          e.evt_id = id_next;
          id_next  = (id_next == teq_pkg::ID_MAX) ? teq_pkg::ID_FIRST : id_next + 1'b1;
        end
      end
      teq_pkg::FUNC_CANCEL: begin
        e.status = teq_pkg::STS_NOT_FOUND;
        found = 1'b0;
        if (r.cancel_id != '0) begin
          for (i = 0; i < ev_count && !found; i++) begin
            if (ev_id[i] == r.cancel_id) begin
              found = 1'b1;
              pos   = i;
            end
          end
        end
        if (found) begin
          drop_event(pos);
          e.status = teq_pkg::STS_CANCELLED;
        end
      end
      teq_pkg::FUNC_TICK: begin
        if (ev_count > 0) begin
          head_time = ev_time[0];
          // Negative times and the largest time count as due at once.
          if (head_time < 0 || head_time == teq_pkg::TIME_MAX ||
              !(r.now < head_time)) begin
            e.status    = teq_pkg::STS_FIRED;
            e.evt_id    = ev_id[0];
            e.fired_tag = ev_tag[0];
            e.fire_time = r.now;
            drop_event(0);
          end
        end
      end
      default: ;
    endcase
    e.occupancy = teq_pkg::CNT_W'(ev_count);
  endtask

  function automatic request_t make_req(input logic [1:0] f,
                                        input logic signed [teq_pkg::TIME_W-1:0] due,
                                        input logic [teq_pkg::TAG_W-1:0] tag,
                                        input logic [teq_pkg::ID_W-1:0] cid,
                                        input logic signed [teq_pkg::TIME_W-1:0] now);
    request_t r;
    r.func      = f;
    r.due_time  = due;
    r.tag       = tag;
    r.cancel_id = cid;
    r.now       = now;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Builds one random request. Fields that the chosen function ignores still
  // carry random values, so every input bit toggles. In a filling phase posts
  // dominate so that the list reaches its capacity; in a draining phase ticks
  // dominate so that it empties again.
  function automatic request_t random_req(input bit filling);
    request_t    r;
    int unsigned pick;
    int unsigned kind;
    r.func      = teq_pkg::FUNC_TICK;
    r.due_time  = rand64();
    r.tag       = teq_pkg::TAG_W'($urandom());
    r.cancel_id = $urandom();
    r.now       = rand64();
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 99);
    if (pick < 3) begin
      r.func = FUNC_NOP;
    end else if (pick < (filling ? 70 : 30)) begin
      r.func = teq_pkg::FUNC_POST;
      if (kind < 65)      r.due_time = wall_now + $urandom_range(0, 500);
      else if (kind < 75) r.due_time = wall_now - $urandom_range(0, 100);
      else if (kind < 85) r.due_time = {1'b1, 63'(rand64())};
      else if (kind < 92) r.due_time = teq_pkg::TIME_MAX;
      else if (kind < 95) r.due_time = wall_now;
    end else if (pick < (filling ? 85 : 50)) begin
      r.func = teq_pkg::FUNC_CANCEL;
      if (kind < 60 && ev_count > 0) r.cancel_id = ev_id[$urandom_range(0, ev_count - 1)];
      else if (kind < 75)            r.cancel_id = id_next - $urandom_range(1, 20);
      else if (kind < 85)            r.cancel_id = '0;
    end else begin
      r.func = teq_pkg::FUNC_TICK;
      if (kind < 88) begin
        wall_now = wall_now + $urandom_range(0, 200);
        r.now    = wall_now;
      end else if (kind < 92) begin
        r.now = teq_pkg::TIME_MAX;
      end else if (kind < 96) begin
        r.now = TIME_MIN;
      end
    end
    return r;
  endfunction

  // Request side. A request that is offered stays on the bus until it is
  // taken; new gaps only open once the current request has gone. valid is
  // given at most one assignment per edge, so back-to-back requests keep it
  // high without a glitch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.func        <= teq_pkg::FUNC_POST;
      req_if.due_time_us <= '0;
      req_if.event_tag   <= '0;
      req_if.cancel_id   <= '0;
      req_if.now_us      <= '0;
      send_gap           <= 0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      if (req_if.valid) begin
        response_t e;
        apply_request(drv_req, e);
        due_responses.push_back(e);
      end
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap     <= $urandom_range(1, 8) - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drv_req = pending_reqs.pop_front();
        req_if.valid       <= 1'b1;
        req_if.func        <= drv_req.func;
        req_if.due_time_us <= drv_req.due_time;
        req_if.event_tag   <= drv_req.tag;
        req_if.cancel_id   <= drv_req.cancel_id;
        req_if.now_us      <= drv_req.now;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response side: every response that is taken is checked against the
  // oldest outstanding expectation, and ready drops in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      take_stall   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_responses.size() == 0) begin
          if (n_errors < 10)
            $display("ERROR: response with none outstanding: status %0d id %0d occ %0d",
                     rsp_if.status, rsp_if.evt_id, rsp_if.occupancy);
          n_errors++;
        end else begin
          response_t e;
          e = due_responses.pop_front();
          if (rsp_if.status !== e.status || rsp_if.evt_id !== e.evt_id ||
              rsp_if.fired_tag !== e.fired_tag || rsp_if.fire_time_us !== e.fire_time ||
              rsp_if.occupancy !== e.occupancy) begin
            if (n_errors < 10) begin
              $display("ERROR: expected status %0d id %0d tag %0d time %0d occ %0d",
                       e.status, e.evt_id, e.fired_tag, e.fire_time, e.occupancy);
              $display("       got      status %0d id %0d tag %0d time %0d occ %0d",
                       rsp_if.status, rsp_if.evt_id, rsp_if.fired_tag,
                       rsp_if.fire_time_us, rsp_if.occupancy);
            end
            n_errors++;
          end
        end
      end
      if (take_stall > 0) begin
        take_stall   <= take_stall - 1;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        take_stall   <= $urandom_range(1, 8) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL timed_event_queue_unit");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    rst_ni = 1'b0;

    // Directed opening. A tick on an empty list finds nothing due, then the
    // list is filled to capacity with the extreme times, two equal times and
    // a spread of others; the seventeenth post is refused as full. Cancels
    // follow for id zero, an id never issued and a pending id, then ticks
    // that fire negative heads and one that finds the head not yet due.
    // Ids wrap only after 2^32 - 1 posts, which is far beyond any practical run.
    pending_reqs.push_back(make_req(teq_pkg::FUNC_TICK, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, teq_pkg::TIME_MAX, 16'hFFFF, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, TIME_MIN, 16'h0000, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, -64'sd1, 16'h00A5, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, 64'sd0, 16'h5A00, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, 64'sd1000, 16'h0001, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, 64'sd1000, 16'h0002, '0, '0));
    for (k = 0; k < 10; k++)
      pending_reqs.push_back(make_req(teq_pkg::FUNC_POST,
                                      teq_pkg::TIME_W'(((k * 7) % 11) * 100 + 50),
                                      teq_pkg::TAG_W'(16'h0100 + k), '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_POST, 64'sd5, 16'hBEEF, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_CANCEL, '0, '0, '0, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_CANCEL, '0, '0, 32'hFFFF_FFFF, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_CANCEL, '0, '0, 32'd6, '0));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_TICK, '0, '0, '0, TIME_MIN));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_TICK, '0, '0, '0, -64'sd5));
    pending_reqs.push_back(make_req(teq_pkg::FUNC_TICK, '0, '0, '0, -64'sd5));
    pending_reqs.push_back(make_req(FUNC_NOP, '0, '0, '0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random part, fed a request or two ahead of the driver so that cancels
    // can aim at ids that are really pending. Phases of filling and draining
    // alternate; the last stretch runs without any idling on either side.
    for (k = 0; k < N_RANDOM; k++) begin
      while (pending_reqs.size() >= 2) @(posedge clk_i);
      if (k >= N_RANDOM - CALM_TAIL) calm = 1'b1;
      pending_reqs.push_back(random_req(((k / 60) % 2) == 0));
    end

    while (pending_reqs.size() > 0 || req_if.valid || due_responses.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("PASS timed_event_queue_unit");
    end else begin
      $display("FAIL timed_event_queue_unit");
    end
    $finish;
  end

endmodule

[timed_event_queue_unit.f]
rtl/core/teq_pkg.sv
rtl/core/teq_req_if.sv
rtl/core/teq_rsp_if.sv
rtl/core/teq_cell.sv
rtl/core/timed_event_queue_unit.sv
tb/tb.sv
